FILE: rtl/pkvba_pkg.sv
// Shared types and constants of the paged KV block allocator.
// Holds command kinds, status codes, controller states and the
// command/status structures between controller and datapath. No dependencies.
`default_nettype none

package pkvba_pkg;

	localparam int MaxBlocks    = 256;
	localparam int MaxSlots     = 32;
	localparam int MaxBlockSize = 256;

	localparam int SlotW  = $clog2(MaxSlots);
	localparam int BlkW   = $clog2(MaxBlocks);
	localparam int CntW   = BlkW + 1;
	localparam int TblAw  = SlotW + BlkW;
	localparam int BsW    = $clog2(MaxBlockSize) + 1;
	localparam int EffSlW = SlotW + 1;

	typedef enum logic [2:0] {
		KIND_ACQUIRE = 3'd0,
		KIND_LOOKUP  = 3'd1,
		KIND_RESERVE = 3'd2,
		KIND_APPEND  = 3'd3,
		KIND_RELEASE = 3'd4,
		KIND_CANCEL  = 3'd5,
		KIND_CLEAR   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_NO_SLOTS  = 3'd3,
		ST_NO_BLOCKS = 3'd4,
		ST_NOT_FOUND = 3'd5,
		ST_STALE     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CFG_BLOCK_SIZE    = 2'd0,
		CFG_BLOCKS_IN_USE = 2'd1,
		CFG_SLOTS_IN_USE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RF_NONE   = 2'd0,
		RF_HANDLE = 2'd1,
		RF_SPAN   = 2'd2
	} res_form_t;

	typedef enum logic [1:0] {
		DV_RESERVE = 2'd0,
		DV_APPEND  = 2'd1,
		DV_FIRST   = 2'd2
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SCAN_END,
		S_ACQ,
		S_HCHK,
		S_DIV_A,
		S_DIV_F,
		S_GCHK,
		S_GROW,
		S_RD_F,
		S_RD_L,
		S_REL,
		S_FIN
	} state_t;

	typedef struct packed {
		logic      in_take;
		logic      scan_step;
		logic      sel_found;
		logic      sel_free;
		logic      sel_handle;
		logic      acq_write;
		logic      div_start;
		div_sel_t  div_sel;
		logic      div_store_a;
		logic      div_store_f;
		logic      grow_start;
		logic      grow_step;
		logic      rel_start;
		logic      rel_step;
		logic      rel_finish;
		logic      clear_all;
		logic      rd_first;
		logic      rd_last;
		logic      cap_first;
		logic      res_load;
		res_form_t res_form;
		status_t   status;
		logic      len_update;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       scan_hit;
		logic       scan_last;
		logic       found;
		logic       free_found;
		logic       hs_in_range;
		logic       handle_ok;
		logic       tc_zero;
		logic       len_ovf;
		logic       div_busy;
		logic       need_le_cnt;
		logic       need_fits;
		logic       grow_done;
		logic       rel_more;
		logic       rel_pending;
		logic       out_free;
	} dp_stat_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  slot;
		logic [31:0] generation;
		logic [31:0] span_tokens;
		logic [31:0] first_position;
		logic [7:0]  first_block;
		logic [7:0]  first_offset;
		logic [15:0] first_address;
		logic [7:0]  last_block;
		logic [7:0]  last_offset;
		logic [15:0] last_address;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/pkvba_div.sv
// Restoring divider, one quotient bit per cycle, for token positions by block size.
// Depends on pkvba_pkg for the divisor width.
`default_nettype none

module pkvba_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [31:0]           dividend,
	input  wire logic [pkvba_pkg::BsW-1:0] divisor,
	output logic                       busy,
	output logic [31:0]                quotient,
	output logic [pkvba_pkg::BsW-1:0]  remainder
);
	import pkvba_pkg::*;

	logic [5:0]     count_q;
	logic [31:0]    quo_q;
	logic [BsW-1:0] rem_q;
	logic [BsW:0]   trial;
	logic [BsW:0]   diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= 6'd32;
		end else if (count_q != 6'd0) begin
			count_q <= count_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (count_q != 6'd0) begin
			// The partial remainder stays below the divisor, so it fits BsW bits.
			if (!diff[BsW]) begin
				rem_q <= diff[BsW-1:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[BsW-1:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy      = (count_q != 6'd0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

FILE: rtl/pkvba_ctrl.sv
// Controller state machine of the paged KV block allocator.
// Depends on pkvba_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module pkvba_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pkvba_pkg::dp_stat_t stat,
	output pkvba_pkg::dp_cmd_t       cmd
);
	import pkvba_pkg::*;

	state_t    state_q, state_d;
	status_t   st_q, st_d;
	res_form_t form_q, form_d;
	logic      is_append;

	assign is_append = (stat.kind == KIND_APPEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			form_q  <= RF_NONE;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			form_q  <= form_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		form_d  = form_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = S_FIN;
				form_d  = RF_NONE;
				unique case (stat.kind)
					KIND_ACQUIRE, KIND_LOOKUP, KIND_CANCEL: state_d = S_SCAN;
					KIND_RESERVE, KIND_APPEND, KIND_RELEASE: begin
						if (stat.hs_in_range) state_d = S_HCHK;
						else st_d = ST_STALE;
					end
					KIND_CLEAR: st_d = ST_OK;
					default:    st_d = ST_INVALID;
				endcase
			end
			S_SCAN: begin
				if (stat.scan_hit || stat.scan_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: begin
				state_d = S_FIN;
				form_d  = RF_NONE;
				unique case (stat.kind)
					KIND_ACQUIRE: begin
						if (stat.found) st_d = ST_DUPLICATE;
						else if (!stat.free_found) st_d = ST_NO_SLOTS;
						else state_d = S_ACQ;
					end
					KIND_LOOKUP: begin
						if (stat.found) begin
							st_d   = ST_OK;
							form_d = RF_HANDLE;
						end else begin
							st_d = ST_NOT_FOUND;
						end
					end
					default: begin
						if (stat.found) state_d = S_REL;
						else st_d = ST_NOT_FOUND;
					end
				endcase
			end
			S_ACQ: begin
				state_d = S_FIN;
				st_d    = ST_OK;
				form_d  = RF_HANDLE;
			end
			S_HCHK: begin
				state_d = S_FIN;
				form_d  = RF_NONE;
				st_d    = ST_OK;
				if (!stat.handle_ok) begin
					st_d = ST_STALE;
				end else begin
					unique case (stat.kind)
						KIND_RELEASE: state_d = S_REL;
						KIND_RESERVE: begin
							if (!stat.tc_zero) state_d = S_DIV_A;
						end
						default: begin
							if (stat.tc_zero) st_d = ST_OK;
							else if (stat.len_ovf) st_d = ST_INVALID;
							else state_d = S_DIV_A;
						end
					endcase
				end
			end
			S_DIV_A: begin
				if (!stat.div_busy) state_d = is_append ? S_DIV_F : S_GCHK;
			end
			S_DIV_F: begin
				if (!stat.div_busy) state_d = S_GCHK;
			end
			S_GCHK: begin
				form_d = RF_NONE;
				st_d   = ST_OK;
				priority if (stat.need_le_cnt) begin
					state_d = is_append ? S_RD_F : S_FIN;
				end else if (!stat.need_fits) begin
					state_d = S_FIN;
					st_d    = ST_NO_BLOCKS;
				end else begin
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				if (stat.grow_done) state_d = is_append ? S_RD_F : S_FIN;
			end
			S_RD_F: state_d = S_RD_L;
			S_RD_L: begin
				state_d = S_FIN;
				st_d    = ST_OK;
				form_d  = RF_SPAN;
			end
			S_REL: begin
				if (!stat.rel_more && !stat.rel_pending) begin
					state_d = S_FIN;
					st_d    = ST_OK;
					form_d  = RF_NONE;
				end
			end
			S_FIN: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.div_sel  = DV_RESERVE;
		cmd.res_form = form_q;
		cmd.status   = st_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_take = in_valid;
			end
			S_DISPATCH: begin
				cmd.clear_all  = (stat.kind == KIND_CLEAR);
				cmd.sel_handle = stat.hs_in_range && ((stat.kind == KIND_RESERVE) ||
					(stat.kind == KIND_APPEND) || (stat.kind == KIND_RELEASE));
			end
			S_SCAN: cmd.scan_step = 1'b1;
			S_SCAN_END: begin
				cmd.sel_free  = (stat.kind == KIND_ACQUIRE) && !stat.found &&
					stat.free_found;
				cmd.sel_found = stat.found && (stat.kind != KIND_ACQUIRE);
				cmd.rel_start = stat.found && (stat.kind == KIND_CANCEL);
			end
			S_ACQ: cmd.acq_write = 1'b1;
			S_HCHK: begin
				if (stat.handle_ok) begin
					unique case (stat.kind)
						KIND_RELEASE: cmd.rel_start = 1'b1;
						KIND_RESERVE: begin
							cmd.div_start = !stat.tc_zero;
							cmd.div_sel   = DV_RESERVE;
						end
						default: begin
							cmd.div_start = !stat.tc_zero && !stat.len_ovf;
							cmd.div_sel   = DV_APPEND;
						end
					endcase
				end
			end
			S_DIV_A: begin
				if (!stat.div_busy) begin
					cmd.div_store_a = 1'b1;
					cmd.div_start   = is_append;
					cmd.div_sel     = DV_FIRST;
				end
			end
			S_DIV_F: cmd.div_store_f = !stat.div_busy;
			S_GCHK:  cmd.grow_start  = !stat.need_le_cnt && stat.need_fits;
			S_GROW:  cmd.grow_step   = !stat.grow_done;
			S_RD_F:  cmd.rd_first    = 1'b1;
			S_RD_L: begin
				cmd.rd_last   = 1'b1;
				cmd.cap_first = 1'b1;
			end
			S_REL: begin
				cmd.rel_step   = stat.rel_more;
				cmd.rel_finish = !stat.rel_more && !stat.rel_pending;
			end
			S_FIN: begin
				cmd.res_load   = stat.out_free;
				cmd.len_update = stat.out_free && (form_q == RF_SPAN);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/pkvba_dp.sv
// Datapath of the paged KV block allocator: slot records, free-block bitmap,
// block table memory, configuration registers, divider and result register.
// Depends on pkvba_pkg and pkvba_div.
`default_nettype none

module pkvba_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [2:0]         in_kind,
	input  wire logic [31:0]        in_req_id,
	input  wire logic [7:0]         in_handle_slot,
	input  wire logic [31:0]        in_handle_generation,
	input  wire logic [31:0]        in_tokens,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [8:0]         cfg_data,
	input  wire pkvba_pkg::dp_cmd_t cmd,
	output pkvba_pkg::dp_stat_t     stat,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output pkvba_pkg::res_t         res
);
	import pkvba_pkg::*;

	// Configuration and latched limits.
	logic [8:0]        cfg_bs_q, cfg_bu_q;
	logic [5:0]        cfg_su_q;
	logic [CntW-1:0]   eff_blocks_q, eff_blocks_d;
	logic [EffSlW-1:0] eff_slots_q, eff_slots_d;
	logic [BsW-1:0]    bsize;

	// Captured item.
	logic [2:0]  kind_q;
	logic [31:0] rid_q, hg_q, tc_q;
	logic [7:0]  hs_q;

	// Slot records.
	logic              active_q [MaxSlots];
	logic [31:0]       req_q    [MaxSlots];
	logic [31:0]       gen_q    [MaxSlots];
	logic [31:0]       len_q    [MaxSlots];
	logic [CntW-1:0]   cnt_q    [MaxSlots];
	logic [SlotW-1:0]  sidx_q, found_idx_q, free_idx_q;
	logic              found_q, free_found_q;
	logic              cur_active;
	logic [31:0]       cur_req, cur_gen, cur_len, gen_next;
	logic [CntW-1:0]   cur_cnt;

	// Blocks.
	logic [MaxBlocks-1:0] free_q;
	logic [CntW-1:0]      fcount_q, rem_q, k_q;
	logic [BlkW-1:0]      bptr_q;
	logic                 pend_q;
	logic                 grow_alloc;
	logic [BlkW-1:0]      bt_mem [MaxSlots*MaxBlocks];
	logic [BlkW-1:0]      bt_rd_q, first_q;
	logic [TblAw-1:0]     bt_raddr;
	logic                 bt_re;

	// Division.
	logic [31:0]    div_dividend, div_quo, qa_q, qf_q;
	logic [BsW-1:0] div_rem;
	logic [7:0]     ra_q, rf_q;
	logic           div_busy;
	logic [32:0]    need, add_blocks, len_sum;

	// Placement of first and last token.
	logic [BlkW-1:0] pb_f, pb_l;
	logic [16:0]     addr_f, addr_l;

	logic   out_valid_q;
	res_t   res_q, res_d;

	assign bsize = (cfg_bs_q == 9'd0) ? BsW'(1) :
		((cfg_bs_q > 9'(MaxBlockSize)) ? BsW'(MaxBlockSize) : BsW'(cfg_bs_q));
	assign eff_blocks_d = (cfg_bu_q == 9'd0) ? CntW'(1) :
		((cfg_bu_q > 9'(MaxBlocks)) ? CntW'(MaxBlocks) : CntW'(cfg_bu_q));
	assign eff_slots_d = (cfg_su_q == 6'd0) ? EffSlW'(1) :
		((cfg_su_q > 6'(MaxSlots)) ? EffSlW'(MaxSlots) : EffSlW'(cfg_su_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bs_q     <= 9'd16;
			cfg_bu_q     <= 9'(MaxBlocks);
			cfg_su_q     <= 6'(MaxSlots);
			eff_blocks_q <= CntW'(MaxBlocks);
			eff_slots_q  <= EffSlW'(MaxSlots);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BLOCK_SIZE:    cfg_bs_q <= cfg_data;
					CFG_BLOCKS_IN_USE: cfg_bu_q <= cfg_data;
					CFG_SLOTS_IN_USE:  cfg_su_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (cmd.clear_all) begin
				eff_blocks_q <= eff_blocks_d;
				eff_slots_q  <= eff_slots_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			kind_q <= in_kind;
			rid_q  <= in_req_id;
			hs_q   <= in_handle_slot;
			hg_q   <= in_handle_generation;
			tc_q   <= in_tokens;
		end
	end

	assign cur_active = active_q[sidx_q];
	assign cur_req    = req_q[sidx_q];
	assign cur_gen    = gen_q[sidx_q];
	assign cur_len    = len_q[sidx_q];
	assign cur_cnt    = cnt_q[sidx_q];
	assign gen_next   = (cur_gen == 32'hFFFF_FFFF) ? 32'd1 : cur_gen + 32'd1;

	// Slot pointer: scans from slot 0 and is then pointed at the chosen slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q       <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			found_idx_q  <= '0;
			free_idx_q   <= '0;
		end else begin
			priority if (cmd.in_take) begin
				sidx_q       <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (stat.scan_hit) begin
					found_q     <= 1'b1;
					found_idx_q <= sidx_q;
				end
				if (!cur_active && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= sidx_q;
				end
				if (!stat.scan_last) sidx_q <= sidx_q + SlotW'(1);
			end else if (cmd.sel_found) begin
				sidx_q <= found_idx_q;
			end else if (cmd.sel_free) begin
				sidx_q <= free_idx_q;
			end else if (cmd.sel_handle) begin
				sidx_q <= hs_q[SlotW-1:0];
			end
		end
	end

	assign grow_alloc = cmd.grow_step && free_q[bptr_q] && (rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxSlots; i++) begin
				active_q[i] <= 1'b0;
				req_q[i]    <= '0;
				gen_q[i]    <= '0;
				len_q[i]    <= '0;
				cnt_q[i]    <= '0;
			end
		end else begin
			priority if (cmd.clear_all) begin
				// Generations survive a clear so that old handles stay stale.
				for (int i = 0; i < MaxSlots; i++) begin
					active_q[i] <= 1'b0;
					req_q[i]    <= '0;
					len_q[i]    <= '0;
					cnt_q[i]    <= '0;
				end
			end else if (cmd.acq_write) begin
				active_q[sidx_q] <= 1'b1;
				req_q[sidx_q]    <= rid_q;
				gen_q[sidx_q]    <= gen_next;
				len_q[sidx_q]    <= '0;
				cnt_q[sidx_q]    <= '0;
			end else if (cmd.rel_finish) begin
				active_q[sidx_q] <= 1'b0;
				req_q[sidx_q]    <= '0;
				len_q[sidx_q]    <= '0;
				cnt_q[sidx_q]    <= '0;
			end else if (grow_alloc && !cur_cnt[CntW-1]) begin
				cnt_q[sidx_q] <= cur_cnt + CntW'(1);
			end else if (cmd.len_update) begin
				len_q[sidx_q] <= cur_len + tc_q;
			end
		end
	end

	// Free bitmap, free count, grow and release walkers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= '1;
			fcount_q <= CntW'(MaxBlocks);
			rem_q    <= '0;
			bptr_q   <= '0;
			k_q      <= '0;
			pend_q   <= 1'b0;
		end else begin
			pend_q <= cmd.rel_step;
			if (cmd.clear_all) begin
				for (int i = 0; i < MaxBlocks; i++)
					free_q[i] <= ($unsigned(i) < 32'(eff_blocks_d));
				fcount_q <= eff_blocks_d;
			end else if (grow_alloc) begin
				free_q[bptr_q] <= 1'b0;
				fcount_q       <= fcount_q - CntW'(1);
			end else if (pend_q && !free_q[bt_rd_q]) begin
				free_q[bt_rd_q] <= 1'b1;
				fcount_q        <= fcount_q + CntW'(1);
			end
			if (cmd.grow_start) begin
				rem_q  <= add_blocks[CntW-1:0];
				bptr_q <= '0;
			end else if (cmd.grow_step) begin
				bptr_q <= bptr_q + BlkW'(1);
				if (grow_alloc) rem_q <= rem_q - CntW'(1);
			end
			if (cmd.rel_start) k_q <= '0;
			else if (cmd.rel_step) k_q <= k_q + CntW'(1);
		end
	end

	// Block table: one write port for grow, one registered read port.
	always_comb begin
		bt_re    = cmd.rel_step || cmd.rd_first || cmd.rd_last;
		bt_raddr = {sidx_q, k_q[BlkW-1:0]};
		if (cmd.rd_first) bt_raddr = {sidx_q, qf_q[BlkW-1:0]};
		else if (cmd.rd_last) bt_raddr = {sidx_q, qa_q[BlkW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (grow_alloc && !cur_cnt[CntW-1]) bt_mem[{sidx_q, cur_cnt[BlkW-1:0]}] <= bptr_q;
		if (bt_re) bt_rd_q <= bt_mem[bt_raddr];
		if (cmd.cap_first) first_q <= bt_rd_q;
	end

	// Division by block size.
	always_comb begin
		unique case (cmd.div_sel)
			DV_RESERVE: div_dividend = tc_q - 32'd1;
			DV_APPEND:  div_dividend = cur_len + tc_q - 32'd1;
			DV_FIRST:   div_dividend = cur_len;
			default:    div_dividend = cur_len;
		endcase
	end

	pkvba_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (bsize),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_store_a) begin
			qa_q <= div_quo;
			ra_q <= div_rem[7:0];
		end
		if (cmd.div_store_f) begin
			qf_q <= div_quo;
			rf_q <= div_rem[7:0];
		end
	end

	assign need       = {1'b0, qa_q} + 33'd1;
	assign add_blocks = need - 33'(cur_cnt);
	assign len_sum    = {1'b0, cur_len} + {1'b0, tc_q};

	assign pb_f   = (qf_q < 32'(cur_cnt)) ? first_q : '0;
	assign pb_l   = (qa_q < 32'(cur_cnt)) ? bt_rd_q : '0;
	assign addr_f = 17'(pb_f) * 17'(bsize) + 17'(rf_q);
	assign addr_l = 17'(pb_l) * 17'(bsize) + 17'(ra_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.res_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_comb begin
		res_d        = '0;
		res_d.status = cmd.status;
		if (cmd.res_form == RF_HANDLE) begin
			res_d.slot       = 5'(sidx_q);
			res_d.generation = cur_gen;
		end
		if (cmd.res_form == RF_SPAN) begin
			res_d.span_tokens    = tc_q;
			res_d.first_position = cur_len;
			res_d.first_block    = 8'(pb_f);
			res_d.first_offset   = rf_q;
			res_d.first_address  = addr_f[15:0];
			res_d.last_block     = 8'(pb_l);
			res_d.last_offset    = ra_q;
			res_d.last_address   = addr_l[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		stat             = '0;
		stat.kind        = kind_q;
		stat.scan_hit    = cur_active && (cur_req == rid_q);
		stat.scan_last   = ({1'b0, sidx_q} == (eff_slots_q - EffSlW'(1)));
		stat.found       = found_q;
		stat.free_found  = free_found_q;
		stat.hs_in_range = ({2'b0, hs_q} < 10'(eff_slots_q));
		stat.handle_ok   = cur_active && (cur_gen == hg_q);
		stat.tc_zero     = (tc_q == 32'd0);
		stat.len_ovf     = len_sum[32];
		stat.div_busy    = div_busy;
		stat.need_le_cnt = (need <= 33'(cur_cnt));
		stat.need_fits   = (add_blocks <= 33'(fcount_q));
		stat.grow_done   = (rem_q == '0);
		stat.rel_more    = (k_q < cur_cnt);
		stat.rel_pending = pend_q;
		stat.out_free    = !out_valid_q || out_ready;
	end

	a_fcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= eff_blocks_q)
		else $error("free block count exceeds managed blocks");

	a_alloc_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		grow_alloc |-> (fcount_q != '0))
		else $error("block taken while free count is zero");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.res_load)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/paged_kv_block_allocator_unit.sv
// Paged KV-cache block allocator. Each command transaction on the slave stream
// yields exactly one result transaction on the master stream. Commands are
// handled one at a time: acquire, lookup and cancel scan the slot records one
// slot per cycle (over at most slots_in_use slots); reserve and append with a
// valid, nonzero token count run a bit-serial divide by the block size (append
// runs it twice), then take any new blocks they need while a pointer walks the
// free bitmap one block index per cycle (over at most blocks_in_use indexes);
// release and cancel return one block per cycle through the block table read
// port. Results sit in an output register, so a new command is taken while
// the previous result still waits. The block table needs no clearing pass after
// reset: entries beyond a slot's block count are never used. Configuration
// writes are taken at any time but are meant to happen only while the block is
// idle; blocks_in_use and slots_in_use take effect at the next clear command.
`default_nettype none

module paged_kv_block_allocator_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// req_id[31:0], handle_slot[39:32], handle_generation[71:40],
	// tokens[103:72]
	input  wire logic [103:0] s_axis_tdata,
	// kind[2:0]
	input  wire logic [2:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// slot[4:0], generation[36:5], span_tokens[68:37], first_position[100:69],
	// first_block[108:101], first_offset[116:109], first_address[132:117],
	// last_block[140:133], last_offset[148:141], last_address[164:149], zeros above
	output logic [167:0]      m_axis_tdata,
	// status[2:0]
	output logic [2:0]        m_axis_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [8:0]   cfg_data
);
	import pkvba_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	res_t     res;

	// Registers accept every write transaction: ready stays high.
	assign cfg_ready = 1'b1;

	pkvba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pkvba_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_kind              (s_axis_tuser),
		.in_req_id            (s_axis_tdata[31:0]),
		.in_handle_slot       (s_axis_tdata[39:32]),
		.in_handle_generation (s_axis_tdata[71:40]),
		.in_tokens            (s_axis_tdata[103:72]),
		.cfg_we               (cfg_valid),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.cmd                  (cmd),
		.stat                 (stat),
		.out_ready            (m_axis_tready),
		.out_valid            (m_axis_tvalid),
		.res                  (res)
	);

	// Fields packed from the lowest bit up; the top three bits pad to whole bytes.
	assign m_axis_tdata = {3'b000, res.last_address, res.last_offset, res.last_block,
		res.first_address, res.first_offset, res.first_block, res.first_position,
		res.span_tokens, res.generation, res.slot};
	assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the paged KV block allocator unit.
// Depends on rtl/pkvba_pkg.sv and rtl/paged_kv_block_allocator_unit.sv; it
// predicts every status and append position with its own allocator model.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pkvba_pkg::*;

	// The slowest commands walk the whole free bitmap or return 256 blocks one by
	// one. The limit applies to the whole run, so it leaves plenty of margin.
	localparam int CycleLimit = 4000000;
	localparam int SettleCycles = 100;
	localparam logic [2:0] KindBad = 3'd7;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [167:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [8:0]   cfg_data;

	paged_kv_block_allocator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Percent of cycles in which the command side and the result side hold off.
	int unsigned cmd_idle_pct;
	int unsigned res_idle_pct;
	int unsigned n_mismatch;
	int unsigned cycle_count;

	// Results still owed by the block, oldest first.
	res_t pending_results[$];

	// ---------------------------------------------------------------------
	// Allocator shadow: registers, latched pool sizes and per-slot records.
	// ---------------------------------------------------------------------
	int unsigned sh_block_size_reg;
	int unsigned sh_blocks_reg;
	int unsigned sh_slots_reg;
	int unsigned sh_blocks;
	int unsigned sh_slots;
	int unsigned sh_free_count;
	bit          sh_active[MaxSlots];
	logic [31:0] sh_request[MaxSlots];
	logic [31:0] sh_gen[MaxSlots];
	logic [31:0] sh_length[MaxSlots];
	int unsigned sh_nblk[MaxSlots];
	logic [7:0]  sh_table[MaxSlots][MaxBlocks];
	bit          sh_free[MaxBlocks];

	function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
			int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned tokens_per_block();
		return clamp_range(sh_block_size_reg, 1, 256);
	endfunction

	// Clear keeps generations so that old handles stay stale afterwards.
	function automatic void pool_clear();
		sh_blocks = clamp_range(sh_blocks_reg, 1, MaxBlocks);
		sh_slots = clamp_range(sh_slots_reg, 1, MaxSlots);
		for (int s = 0; s < MaxSlots; s++) begin
			sh_active[s] = 1'b0;
			sh_request[s] = '0;
			sh_length[s] = '0;
			sh_nblk[s] = 0;
		end
		for (int b = 0; b < MaxBlocks; b++) sh_free[b] = (b < sh_blocks);
		sh_free_count = sh_blocks;
	endfunction

	function automatic int find_owner(logic [31:0] rid);
		for (int s = 0; s < sh_slots; s++)
			if (sh_active[s] && sh_request[s] == rid) return s;
		return -1;
	endfunction

	function automatic bit handle_valid(logic [7:0] hs, logic [31:0] hg);
		if (hs >= sh_slots) return 1'b0;
		return sh_active[hs] && sh_gen[hs] == hg;
	endfunction

	function automatic int unsigned blocks_needed(logic [31:0] tokens);
		if (tokens == 0) return 0;
		return 1 + (tokens - 1) / tokens_per_block();
	endfunction

	// Takes free blocks lowest index first until the slot holds 'need' blocks.
	function automatic status_t grow_slot(int s, int unsigned need);
		int unsigned add;
		int b;
		if (need <= sh_nblk[s]) return ST_OK;
		add = need - sh_nblk[s];
		if (add > sh_free_count) return ST_NO_BLOCKS;
		for (int k = 0; k < add; k++) begin
			for (b = 0; b < sh_blocks; b++)
				if (sh_free[b]) break;
			if (b >= sh_blocks) break;
			sh_free[b] = 1'b0;
			sh_free_count--;
			if (sh_nblk[s] < MaxBlocks) begin
				sh_table[s][sh_nblk[s]] = b[7:0];
				sh_nblk[s]++;
			end
		end
		return ST_OK;
	endfunction

	function automatic void free_slot_blocks(int s);
		for (int k = 0; k < sh_nblk[s] && k < MaxBlocks; k++) begin
			if (!sh_free[sh_table[s][k]]) begin
				sh_free[sh_table[s][k]] = 1'b1;
				sh_free_count++;
			end
		end
		sh_active[s] = 1'b0;
		sh_request[s] = '0;
		sh_length[s] = '0;
		sh_nblk[s] = 0;
	endfunction

	function automatic void locate(int s, logic [31:0] pos, output logic [7:0] blk,
			output logic [7:0] off, output logic [15:0] addr);
		int unsigned bs;
		int unsigned lb;
		int unsigned o;
		int unsigned pb;
		bs = tokens_per_block();
		lb = pos / bs;
		o = pos % bs;
		pb = 0;
		if (lb < sh_nblk[s] && lb < MaxBlocks) pb = sh_table[s][lb];
		blk = pb[7:0];
		off = o[7:0];
		addr = 16'(pb * bs + o);
	endfunction

	// Applies one command to the shadow and returns the result it must produce.
	function automatic res_t allocator_step(logic [2:0] kind, logic [31:0] rid,
			logic [7:0] hs, logic [31:0] hg, logic [31:0] tc);
		res_t r;
		int f;
		int s;
		logic [31:0] old_len;
		logic [31:0] new_len;
		r = '0;
		r.status = ST_OK;
		case (kind)
			KIND_ACQUIRE: begin
				if (find_owner(rid) >= 0) begin
					r.status = ST_DUPLICATE;
				end else begin
					for (s = 0; s < sh_slots; s++)
						if (!sh_active[s]) break;
					if (s >= sh_slots) begin
						r.status = ST_NO_SLOTS;
					end else begin
						sh_gen[s] = sh_gen[s] + 1;
						if (sh_gen[s] == 0) sh_gen[s] = 1;
						sh_request[s] = rid;
						sh_length[s] = '0;
						sh_nblk[s] = 0;
						sh_active[s] = 1'b1;
						r.slot = s[4:0];
						r.generation = sh_gen[s];
					end
				end
			end
			KIND_LOOKUP: begin
				f = find_owner(rid);
				if (f < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.slot = f[4:0];
					r.generation = sh_gen[f];
				end
			end
			KIND_RESERVE: begin
				if (!handle_valid(hs, hg)) r.status = ST_STALE;
				else r.status = grow_slot(hs, blocks_needed(tc));
			end
			KIND_APPEND: begin
				if (!handle_valid(hs, hg)) begin
					r.status = ST_STALE;
				end else if (tc != 0) begin
					old_len = sh_length[hs];
					if (tc > 32'hFFFF_FFFF - old_len) begin
						r.status = ST_INVALID;
					end else begin
						new_len = old_len + tc;
						r.status = grow_slot(hs, blocks_needed(new_len));
						if (r.status == ST_OK) begin
							r.span_tokens = tc;
							r.first_position = old_len;
							locate(hs, old_len, r.first_block, r.first_offset,
								r.first_address);
							locate(hs, new_len - 1, r.last_block, r.last_offset,
								r.last_address);
							sh_length[hs] = new_len;
						end
					end
				end
			end
			KIND_RELEASE: begin
				if (!handle_valid(hs, hg)) r.status = ST_STALE;
				else free_slot_blocks(hs);
			end
			KIND_CANCEL: begin
				f = find_owner(rid);
				if (f < 0) r.status = ST_NOT_FOUND;
				else free_slot_blocks(f);
			end
			KIND_CLEAR: pool_clear();
			default: r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Result side: random back-pressure and field-by-field comparison.
	// ---------------------------------------------------------------------
	function automatic void compare_field(string name, logic [31:0] want,
			logic [31:0] got);
		if (want !== got) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("MISMATCH %s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function automatic void check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			n_mismatch++;
			if (n_mismatch <= 10) $display("MISMATCH: result with none outstanding");
			return;
		end
		want = pending_results.pop_front();
		compare_field("status", want.status, m_axis_tuser);
		compare_field("slot", want.slot, m_axis_tdata[4:0]);
		compare_field("generation", want.generation, m_axis_tdata[36:5]);
		compare_field("span_tokens", want.span_tokens, m_axis_tdata[68:37]);
		compare_field("first_position", want.first_position, m_axis_tdata[100:69]);
		compare_field("first_block", want.first_block, m_axis_tdata[108:101]);
		compare_field("first_offset", want.first_offset, m_axis_tdata[116:109]);
		compare_field("first_address", want.first_address, m_axis_tdata[132:117]);
		compare_field("last_block", want.last_block, m_axis_tdata[140:133]);
		compare_field("last_offset", want.last_offset, m_axis_tdata[148:141]);
		compare_field("last_address", want.last_address, m_axis_tdata[164:149]);
		compare_field("tdata_pad", 32'h0, m_axis_tdata[167:165]);
	endfunction

	// Outputs are sampled right at the clock edge, before any flop updates.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) check_result();
			m_axis_tready <= ($urandom_range(99) >= res_idle_pct);
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Command side helpers.
	// ---------------------------------------------------------------------

	// One command transaction. Valid stays high across back-to-back commands and
	// only drops for an idle gap, so it is never lowered and raised in one step.
	task automatic send_command(logic [2:0] kind, logic [31:0] rid, logic [7:0] hs,
			logic [31:0] hg, logic [31:0] tc);
		pending_results.insert(pending_results.size(),
			allocator_step(kind, rid, hs, hg, tc));
		while ($urandom_range(99) < cmd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {tc, hg, hs, rid};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stops sending and waits until every result is back and the block is idle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[8:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_BLOCK_SIZE:    sh_block_size_reg = value & 9'h1FF;
			CFG_BLOCKS_IN_USE: sh_blocks_reg = value & 9'h1FF;
			default:           sh_slots_reg = value & 6'h3F;
		endcase
	endtask

	// Pool sizes only take effect at a clear, so one follows every setting.
	task automatic set_pool(int unsigned bs, int unsigned nblk, int unsigned nslot);
		wait_idle();
		write_register(CFG_BLOCK_SIZE, bs);
		write_register(CFG_BLOCKS_IN_USE, nblk);
		write_register(CFG_SLOTS_IN_USE, nslot);
		send_command(KIND_CLEAR, '0, '0, '0, '0);
	endtask

	// Request ids come mostly from a small set so that duplicates, lookups and
	// cancels hit; the rest are full-width random.
	function automatic logic [31:0] pick_request();
		if ($urandom_range(99) < 80) return $urandom_range(0, 11);
		return $urandom;
	endfunction

	// Handles are mostly live ones taken from the shadow, otherwise garbage.
	function automatic void pick_handle(output logic [7:0] hs, output logic [31:0] hg);
		int s;
		hs = 8'($urandom_range(0, 255));
		hg = $urandom;
		if ($urandom_range(99) < 88) begin
			s = $urandom_range(0, sh_slots - 1);
			for (int k = 0; k < sh_slots; k++) begin
				if (sh_active[(s + k) % sh_slots]) begin
					hs = 8'((s + k) % sh_slots);
					hg = sh_gen[hs];
					if ($urandom_range(99) < 4) hg = hg + 1;
					break;
				end
			end
		end
	endfunction

	function automatic logic [31:0] pick_tokens();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(0, 3 * tokens_per_block());
		if (r < 85) return $urandom_range(0, 40 * tokens_per_block());
		if (r < 93) return $urandom;
		return 32'hFFFF_FFFF - $urandom_range(0, 3);
	endfunction

	// Mostly acquire/append/release flows on live handles, with some noise.
	task automatic run_random(int n);
		int unsigned r;
		logic [2:0] kind;
		logic [7:0] hs;
		logic [31:0] hg;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(999);
			if (r < 200) kind = KIND_ACQUIRE;
			else if (r < 290) kind = KIND_LOOKUP;
			else if (r < 440) kind = KIND_RESERVE;
			else if (r < 740) kind = KIND_APPEND;
			else if (r < 870) kind = KIND_RELEASE;
			else if (r < 970) kind = KIND_CANCEL;
			else if (r < 985) kind = KIND_CLEAR;
			else kind = KindBad;
			pick_handle(hs, hg);
			send_command(kind, pick_request(), hs, hg, pick_tokens());
			// Now and then let the block drain completely before going on.
			if (i % 200 == 199) wait_idle();
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests.
	// ---------------------------------------------------------------------

	// Every command kind and most of its error cases at the reset configuration.
	task automatic test_directed();
		send_command(KIND_ACQUIRE, 32'h0, '0, '0, '0);
		send_command(KIND_ACQUIRE, 32'hFFFF_FFFF, '0, '0, '0);
		send_command(KIND_ACQUIRE, 32'h0, '0, '0, '0);
		send_command(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
		send_command(KIND_LOOKUP, 32'h1234_5678, '0, '0, '0);
		send_command(KIND_RESERVE, '0, 8'd0, sh_gen[0], 32'd40);
		// An empty append is accepted but changes nothing.
		send_command(KIND_APPEND, '0, 8'd0, sh_gen[0], 32'd0);
		send_command(KIND_APPEND, '0, 8'd0, sh_gen[0], 32'd50);
		// The slot length would pass the 32-bit limit.
		send_command(KIND_APPEND, '0, 8'd0, sh_gen[0], 32'hFFFF_FFFF);
		// More blocks than the pool holds.
		send_command(KIND_APPEND, '0, 8'd1, sh_gen[1], 32'd5000);
		send_command(KIND_RESERVE, '0, 8'd1, sh_gen[1], 32'hFFFF_FFFF);
		send_command(KIND_RESERVE, '0, 8'd255, 32'hFFFF_FFFF, 32'd1);
		send_command(KIND_RESERVE, '0, 8'd1, sh_gen[1] ^ 32'h8000_0000, 32'd1);
		send_command(KIND_APPEND, '0, 8'd1, sh_gen[1], 32'd17);
		send_command(KIND_RELEASE, '0, 8'd0, sh_gen[0], '0);
		send_command(KIND_RELEASE, '0, 8'd0, sh_gen[0], '0);
		send_command(KIND_ACQUIRE, 32'h5555_AAAA, '0, '0, '0);
		send_command(KIND_APPEND, '0, 8'd0, sh_gen[0], 32'd33);
		send_command(KIND_CANCEL, 32'hFFFF_FFFF, '0, '0, '0);
		send_command(KIND_CANCEL, 32'hFFFF_FFFF, '0, '0, '0);
		send_command(KindBad, $urandom, 8'($urandom_range(0, 255)), $urandom, $urandom);
		send_command(KIND_CLEAR, '0, '0, '0, '0);
		send_command(KIND_LOOKUP, 32'h5555_AAAA, '0, '0, '0);
	endtask

	// Smallest pool: one slot, one block, one token per block.
	task automatic test_tiny_pool();
		set_pool(1, 1, 1);
		send_command(KIND_ACQUIRE, 32'd7, '0, '0, '0);
		send_command(KIND_ACQUIRE, 32'd8, '0, '0, '0);
		send_command(KIND_APPEND, '0, 8'd0, sh_gen[0], 32'd1);
		send_command(KIND_APPEND, '0, 8'd0, sh_gen[0], 32'd1);
		send_command(KIND_RESERVE, '0, 8'd1, '0, 32'd1);
		run_random(150);
	endtask

	// Largest block size and full pool.
	task automatic test_full_pool();
		set_pool(256, 256, 32);
		for (int i = 0; i < 33; i++) send_command(KIND_ACQUIRE, 32'h100 + i, '0, '0, '0);
		send_command(KIND_APPEND, '0, 8'd31, sh_gen[31], 32'd65536);
		send_command(KIND_APPEND, '0, 8'd30, sh_gen[30], 32'd1);
		send_command(KIND_RELEASE, '0, 8'd31, sh_gen[31], '0);
		send_command(KIND_CLEAR, '0, '0, '0, '0);
		run_random(260);
	endtask

	task automatic test_random_pools();
		for (int p = 0; p < 5; p++) begin
			set_pool($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(1, 32));
			run_random(100);
		end
		set_pool(16, 256, 32);
		run_random(70);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BLOCK_SIZE;
		cfg_data = '0;
		n_mismatch = 0;
		cmd_idle_pct = 23;
		res_idle_pct = 71;

		// Shadow starts from the reset configuration.
		sh_block_size_reg = 16;
		sh_blocks_reg = 256;
		sh_slots_reg = 32;
		for (int s = 0; s < MaxSlots; s++) sh_gen[s] = '0;
		pool_clear();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		run_random(400);

		wait_idle();
		cmd_idle_pct = 71;
		res_idle_pct = 23;
		test_tiny_pool();
		test_full_pool();

		wait_idle();
		cmd_idle_pct = 0;
		res_idle_pct = 0;
		test_random_pools();

		wait_idle();
		if (n_mismatch == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/pkvba_pkg.sv
rtl/pkvba_div.sv
rtl/pkvba_ctrl.sv
rtl/pkvba_dp.sv
rtl/paged_kv_block_allocator_unit.sv
tb/tb_top.sv
